// File: src/assert_macros.svh
// Assertion macros shared by the deque RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BDQS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define BDQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDQS_ASSERT(lbl, clk, rst_n, prop)
`define BDQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/bdqs_pkg.sv
// Types, codes and sizing constants of the bounded deque with search.
// Depends on nothing; imported by the interfaces, the cell and the top level.
package bdqs_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [TOTAL_W-1:0]        t_total;
    typedef logic [CNT_W-1:0]          t_count;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_CONTAINS   = 3'd4;
    localparam t_cmd CMD_REMOVE     = 3'd5;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Control broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic   push_front;
        logic   push_back;
        logic   pop_front;
        logic   remove;
    } t_cell_ctrl;

    // Position of one cell relative to the current fill level.
    typedef struct packed {
        logic occ;
        logic tail;
    } t_cell_pos;

endpackage

// File: src/bdqs_if.sv
// Valid/ready channel interfaces for commands and results of the deque.
// Depends on bdqs_pkg.
interface bdqs_cmd_if;
    import bdqs_pkg::*;
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_value operand_value;
    modport source (output valid, output command, output operand_value, input ready);
    modport sink (input valid, input command, input operand_value, output ready);
endinterface

interface bdqs_res_if;
    import bdqs_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    logic    found;
    t_value  front_value;
    t_value  back_value;
    t_total  entry_total;
    logic    is_empty;
    modport source (output valid, output status, output found, output front_value,
                    output back_value, output entry_total, output is_empty, input ready);
    modport sink (input valid, input status, input found, input front_value,
                  input back_value, input entry_total, input is_empty, output ready);
endinterface

// File: src/bdqs_cell.sv
// One storage cell of the deque chain: holds a value, compares it, shifts.
// Depends on bdqs_pkg.
module bdqs_cell (
    input  logic                i_clk,
    input  bdqs_pkg::t_cell_ctrl i_ctrl,
    input  bdqs_pkg::t_value     i_operand,
    input  bdqs_pkg::t_cell_pos  i_pos,
    input  bdqs_pkg::t_value     i_left_value,
    input  bdqs_pkg::t_value     i_right_value,
    input  logic                i_hit,
    output bdqs_pkg::t_value     o_value,
    output logic                o_hit
);
    import bdqs_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   w_match;

    assign w_match = i_pos.occ && (r_value == i_operand);
    // The hit chain marks the first matching cell and every cell behind it.
    assign o_hit   = i_hit || w_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.push_front) begin
            n_value = i_left_value;
        end else if (i_ctrl.pop_front || (i_ctrl.remove && o_hit)) begin
            n_value = i_right_value;
        end else if (i_ctrl.push_back && i_pos.tail) begin
            n_value = i_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: src/bounded_deque_with_search_unit.sv
// Bounded deque with membership search, built as a chain of storage cells.
// An accepted item updates the cells and sets the busy register; the output register then
// samples front, back and count and the result goes valid. A new item is taken only when
// the block is not busy and no result is held, or the held result is being taken.
// Reset (synchronous, active low) empties the deque and drops any pending result;
// cell contents are not cleared.
`include "assert_macros.svh"
module bounded_deque_with_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdqs_cmd_if.sink    i_cmd,
    bdqs_res_if.source  o_res
);
    import bdqs_pkg::*;

    t_count     r_count;
    t_count     n_count;
    logic       r_busy;
    logic       r_out_valid;
    t_status    r_status;
    t_status    n_status;
    logic       r_found;
    logic       n_found;
    t_value     r_front;
    t_value     r_back;
    t_total     r_total;
    logic       r_is_empty;

    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;
    t_cell_pos  w_pos   [CAPACITY];
    t_value     w_value [CAPACITY];
    logic       w_hit   [CAPACITY+1];
    logic       w_last  [CAPACITY];
    t_value     w_front;
    t_value     w_back;

    assign i_cmd.ready = !r_busy && (!r_out_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_hit[0]    = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_value w_left;
            t_value w_right;
            assign w_pos[gi].occ  = (CNT_W'(gi) < r_count);
            assign w_pos[gi].tail = (CNT_W'(gi) == r_count);
            assign w_last[gi]     = (CNT_W'(gi + 1) == r_count);
            if (gi == 0) begin : g_first
                assign w_left = i_cmd.operand_value;
            end else begin : g_mid
                assign w_left = w_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_end
                assign w_right = w_value[gi];
            end else begin : g_inner
                assign w_right = w_value[gi+1];
            end
            bdqs_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_operand     (i_cmd.operand_value),
                .i_pos         (w_pos[gi]),
                .i_left_value  (w_left),
                .i_right_value (w_right),
                .i_hit         (w_hit[gi]),
                .o_value       (w_value[gi]),
                .o_hit         (w_hit[gi+1])
            );
        end
    endgenerate

    // Decode the command; cell control is only raised on an accepted item.
    always_comb begin
        w_ctrl         = '0;
        n_status       = ST_OK;
        n_found        = 1'b0;
        n_count        = r_count;
        unique case (i_cmd.command)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push_front = w_accept;
                    n_count           = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push_back = w_accept;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop_front = w_accept;
                    n_count          = r_count - CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_CONTAINS: begin
                if (w_hit[CAPACITY]) begin
                    n_found = 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_REMOVE: begin
                if (w_hit[CAPACITY]) begin
                    n_found       = 1'b1;
                    w_ctrl.remove = w_accept;
                    n_count       = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Front and back readout from the cells as they stand after the update.
    always_comb begin
        w_front = w_empty ? '0 : w_value[0];
        w_back  = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_last[k]) begin
                w_back = w_back | w_value[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (r_busy) begin
            r_front    <= w_front;
            r_back     <= w_back;
            r_total    <= TOTAL_W'(r_count);
            r_is_empty <= w_empty;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.found       = r_found;
    assign o_res.front_value = r_front;
    assign o_res.back_value  = r_back;
    assign o_res.entry_total = r_total;
    assign o_res.is_empty    = r_is_empty;

    `BDQS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `BDQS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_busy && !r_out_valid)
    `BDQS_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, r_busy, r_out_valid && !r_busy)
    `BDQS_ASSERT(a_found_ok, i_clk, i_rst_n, !(r_out_valid && r_found) || (r_status == ST_OK))

endmodule

// File: dv/bounded_deque_with_search_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded deque with membership search.
// A directed run over the corner cases, then random command mixes under varying
// backpressure, all checked against a queue-based shadow deque. Depends on bdqs_pkg.
module bounded_deque_with_search_unit_tb;
    import bdqs_pkg::*;

    localparam t_cmd   CMD_PEEK   = 3'd6;
    localparam t_cmd   CMD_SPARE  = 3'd7;
    localparam t_value VALUE_MIN  = 32'sh8000_0000;
    localparam t_value VALUE_MAX  = 32'sh7fff_ffff;
    localparam int     RANDOM_ITEMS = 800;
    localparam int     MAX_REPORTS  = 10;

    typedef struct {
        t_cmd   command;
        t_value operand;
        int     phase;
    } t_deque_cmd_item;

    typedef struct {
        t_status status;
        logic    found;
        t_value  front_value;
        t_value  back_value;
        t_total  entry_total;
        logic    is_empty;
    } t_deque_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdqs_cmd_if cmd_if ();
    bdqs_res_if res_if ();

    bounded_deque_with_search_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #10 i_clk = ~i_clk;

    t_deque_cmd_item pending_items[$];
    t_deque_outcome  awaited_outcomes[$];
    t_value          deque_shadow[$];
    int              backpressure_phase = 0;
    int              mismatch_total = 0;

    // Shadow deque: applies one command and returns the result the block must give.
    function automatic t_deque_outcome predict_deque_outcome(t_cmd cmd, t_value val);
        t_deque_outcome r;
        int pos;
        r.status = ST_OK;
        r.found  = 1'b0;
        pos      = -1;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (deque_shadow.size() >= CAPACITY) r.status = ST_FULL;
                else deque_shadow.push_front(val);
            end
            CMD_PUSH_BACK: begin
                if (deque_shadow.size() >= CAPACITY) r.status = ST_FULL;
                else deque_shadow.push_back(val);
            end
            CMD_POP_FRONT: begin
                if (deque_shadow.size() == 0) r.status = ST_EMPTY;
                else void'(deque_shadow.pop_front());
            end
            CMD_POP_BACK: begin
                if (deque_shadow.size() == 0) r.status = ST_EMPTY;
                else void'(deque_shadow.pop_back());
            end
            CMD_CONTAINS, CMD_REMOVE: begin
                foreach (deque_shadow[i])
                    if (pos < 0 && deque_shadow[i] == val) pos = i;
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    if (cmd == CMD_REMOVE) deque_shadow.delete(pos);
                end
            end
            default: ;
        endcase
        r.entry_total = t_total'(deque_shadow.size());
        r.is_empty    = (deque_shadow.size() == 0);
        r.front_value = (deque_shadow.size() == 0) ? t_value'(0) : deque_shadow[0];
        r.back_value  = (deque_shadow.size() == 0) ? t_value'(0) : deque_shadow[$];
        return r;
    endfunction

    // Phase 0 runs flat out; 1 idles the sender, 2 stalls the receiver, 3 does both lightly.
    function automatic bit sender_idles(int ph);
        case (ph)
            1:       return $urandom_range(99) < 70;
            3:       return $urandom_range(99) < 21;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls(int ph);
        case (ph)
            2:       return $urandom_range(99) < 70;
            3:       return $urandom_range(99) < 21;
            default: return 1'b0;
        endcase
    endfunction

    // A small pool of values keeps duplicates and search hits frequent.
    function automatic t_value pick_operand();
        case ($urandom_range(11))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return t_value'(0);
            4, 5:    return t_value'(-1);
            6, 7:    return t_value'(7);
            8:       return t_value'(-5);
            default: return t_value'($urandom);
        endcase
    endfunction

    // Mode 0 leans toward pushes to reach full, mode 1 toward pops to reach empty.
    function automatic t_cmd pick_command(int mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            0:       return (roll < 70) ? t_cmd'($urandom_range(1)) : t_cmd'($urandom_range(7, 2));
            1:       return (roll < 55) ? t_cmd'($urandom_range(3, 2)) : t_cmd'($urandom_range(7));
            default: return t_cmd'($urandom_range(7));
        endcase
    endfunction

    function automatic void queue_item(t_cmd cmd, t_value val, int ph);
        t_deque_cmd_item it;
        it.command = cmd;
        it.operand = val;
        it.phase   = ph;
        pending_items.push_back(it);
    endfunction

    // Command driver: holds an offered item until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_if.valid) begin
                awaited_outcomes.push_back(
                    predict_deque_outcome(cmd_if.command, cmd_if.operand_value));
                void'(pending_items.pop_front());
            end
            if (pending_items.size() > 0 && !sender_idles(pending_items[0].phase)) begin
                cmd_if.valid         <= 1'b1;
                cmd_if.command       <= pending_items[0].command;
                cmd_if.operand_value <= pending_items[0].operand;
                backpressure_phase   <= pending_items[0].phase;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each taken result against the oldest prediction.
    always @(posedge i_clk) begin
        t_deque_outcome want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS)
                        $display("unexpected result: total=%0d front=%0d back=%0d",
                                 res_if.entry_total, res_if.front_value, res_if.back_value);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (res_if.status !== want.status || res_if.found !== want.found ||
                        res_if.front_value !== want.front_value ||
                        res_if.back_value !== want.back_value ||
                        res_if.entry_total !== want.entry_total ||
                        res_if.is_empty !== want.is_empty) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTS) begin
                            $display("mismatch: expected status=%0d found=%0d front=%0d back=%0d total=%0d empty=%0d",
                                     want.status, want.found, want.front_value,
                                     want.back_value, want.entry_total, want.is_empty);
                            $display("          actual   status=%0d found=%0d front=%0d back=%0d total=%0d empty=%0d",
                                     res_if.status, res_if.found, res_if.front_value,
                                     res_if.back_value, res_if.entry_total, res_if.is_empty);
                        end
                    end
                end
            end
            res_if.ready <= !receiver_stalls(backpressure_phase);
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_PEEK;
        cmd_if.operand_value = '0;
        res_if.ready         = 1'b0;

        // Corner cases on an empty deque, including the unused codes.
        queue_item(CMD_PEEK, 0, 0);
        queue_item(CMD_SPARE, VALUE_MAX, 0);
        queue_item(CMD_POP_FRONT, 0, 0);
        queue_item(CMD_POP_BACK, 0, 0);
        queue_item(CMD_CONTAINS, 0, 0);
        queue_item(CMD_REMOVE, 0, 0);
        // Extremes and duplicates; remove must take the copy nearest the front.
        queue_item(CMD_PUSH_FRONT, VALUE_MAX, 0);
        queue_item(CMD_PUSH_BACK, VALUE_MIN, 0);
        queue_item(CMD_PUSH_FRONT, VALUE_MIN, 0);
        queue_item(CMD_PUSH_BACK, 0, 0);
        queue_item(CMD_PUSH_BACK, -1, 0);
        queue_item(CMD_CONTAINS, VALUE_MIN, 0);
        queue_item(CMD_CONTAINS, 12345, 0);
        queue_item(CMD_REMOVE, VALUE_MIN, 0);
        queue_item(CMD_REMOVE, 12345, 0);
        queue_item(CMD_PEEK, VALUE_MIN, 0);
        queue_item(CMD_REMOVE, -1, 0);
        queue_item(CMD_POP_BACK, 0, 0);
        queue_item(CMD_POP_FRONT, 0, 0);
        queue_item(CMD_POP_FRONT, 0, 0);
        queue_item(CMD_SPARE, 0, 0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
            queue_item(pick_command((k / 40) % 3), pick_operand(), (k / 100) % 4);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || cmd_if.valid) @(posedge i_clk);
        while (awaited_outcomes.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_total == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
